/* design/mbvm_pkg.sv */
// Package for the mesh boundary vertex marker.
// Holds index, key and bitmap widths and the parameter defaults.
// No dependencies.
package mbvm_pkg;
    localparam int IDX_W         = 10;
    localparam int KEY_W         = 2 * IDX_W;
    localparam int IDX_LIMIT     = 1 << IDX_W;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;
    localparam int ROW_CNT       = IDX_LIMIT / WORD_W;
    localparam int ROW_W         = 4;
    localparam int VCNT_W        = 11;
    localparam int DEF_MAX_VERTS = 1024;
    localparam int DEF_MAX_FACES = 2048;
endpackage

/* design/mesh_boundary_vertex_marker.sv */
// Mesh boundary vertex marker: edge key store, pairwise count scan, bitmaps.
// Depends on mbvm_pkg.
//
//  channel | signals                                         | direction
//  in      | i_in_valid, o_in_stall, corners, last_face      | into block
//  out     | o_out_valid, i_out_stall, word fields           | out of block
//  cfg     | i_cfg_we, i_cfg_wdata (vertex_count)            | into block
//
// A triangle is accepted, its edge keys are written, the used marks of its
// corners are read and rewritten, and then it is checked for the last one; a
// dropped triangle skips the keys and marks. After the last triangle, each stored
// key is compared against the stored keys, stopping at a second match, and each
// boundary edge marks both its vertices. Each bitmap word is then read and sent,
// held while the output is stalled. Reset and the end of each mesh start a
// clearing pass of the maps. Input is stalled whenever the sequencer is not idle.
module mesh_boundary_vertex_marker #(
    parameter int MAX_VERTS = mbvm_pkg::DEF_MAX_VERTS,
    parameter int MAX_FACES = mbvm_pkg::DEF_MAX_FACES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mbvm_pkg::VCNT_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [mbvm_pkg::IDX_W-1:0] i_corner_a,
    input  logic [mbvm_pkg::IDX_W-1:0] i_corner_b,
    input  logic [mbvm_pkg::IDX_W-1:0] i_corner_c,
    input  logic                      i_last_face,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [mbvm_pkg::ROW_W-1:0] o_word_index,
    output logic [mbvm_pkg::WORD_W-1:0] o_used_bits,
    output logic [mbvm_pkg::WORD_W-1:0] o_boundary_bits,
    output logic                      o_overflow,
    output logic                      o_last_word
);
    import mbvm_pkg::*;

    localparam int EDGE_CAP = 3 * MAX_FACES;
    localparam int ADDR_W   = $clog2(EDGE_CAP);
    localparam int FILL_W   = $clog2(EDGE_CAP + 1);
    localparam int CNT_LIM  = (MAX_VERTS < IDX_LIMIT) ? MAX_VERTS : IDX_LIMIT;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_EDGE, S_UMRD, S_UMWR, S_CHK,
        S_SI, S_SK, S_SJ, S_SC, S_SD, S_BMRD, S_BMWR,
        S_ORD, S_OLD, S_OVL
    } t_state;

    t_state                 r_state;
    logic [VCNT_W-1:0]      r_vertex_count;
    logic [IDX_W-1:0]       r_a, r_b, r_c;
    logic                   r_last;
    logic [1:0]             r_k;
    logic [FILL_W-1:0]      r_fill, r_i, r_j;
    logic [1:0]             r_cnt;
    logic [KEY_W-1:0]       r_key;
    logic                   r_dropped;
    logic [ROW_W-1:0]       r_row;
    logic                   r_out_valid;
    logic [ROW_W-1:0]       r_word_index;
    logic [WORD_W-1:0]      r_used_bits, r_boundary_bits;
    logic                   r_overflow, r_last_word;

    logic [KEY_W-1:0]       edge_mem [EDGE_CAP];
    logic [KEY_W-1:0]       r_edge_q;
    logic [WORD_W-1:0]      used_mem [ROW_CNT];
    logic [WORD_W-1:0]      bnd_mem  [ROW_CNT];
    logic [WORD_W-1:0]      r_used_q, r_bnd_q;

    logic                   edge_we;
    logic [ADDR_W-1:0]      edge_waddr, edge_raddr;
    logic [KEY_W-1:0]       edge_wdata;
    logic [IDX_W-1:0]       ek_x, ek_y, mv_u, mv_b;
    logic                   used_we, bnd_we;
    logic [ROW_W-1:0]       used_addr, bnd_addr;
    logic [WORD_W-1:0]      used_wdata, bnd_wdata;
    logic [VCNT_W-1:0]      count, rem;
    logic [ROW_W:0]         words;
    logic [WORD_W-1:0]      mask;
    logic                   fits;
    logic [1:0]             n_cnt;
    logic [FILL_W-1:0]      n_j;

    always_comb begin
        count = r_vertex_count;
        if (count == '0) begin
            count = VCNT_W'(1);
        end
        if (32'(count) > CNT_LIM) begin
            count = VCNT_W'(CNT_LIM);
        end
        words = (ROW_W + 1)'((count + VCNT_W'(WORD_W - 1)) >> BIT_W);
        rem   = count - {r_row, {BIT_W{1'b0}}};
        mask  = (rem >= VCNT_W'(WORD_W)) ? '1
              : ((WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1));
    end

    always_comb begin
        case (r_k)
            2'd0:    begin ek_x = r_a; ek_y = r_b; mv_u = r_a; end
            2'd1:    begin ek_x = r_b; ek_y = r_c; mv_u = r_b; end
            default: begin ek_x = r_c; ek_y = r_a; mv_u = r_c; end
        endcase
        mv_b       = (r_k == 2'd0) ? r_key[KEY_W-1:IDX_W] : r_key[IDX_W-1:0];
        edge_wdata = (ek_x < ek_y) ? {ek_x, ek_y} : {ek_y, ek_x};
        fits       = ((FILL_W + 1)'(r_fill) + (FILL_W + 1)'(3))
                     <= (FILL_W + 1)'(EDGE_CAP);
        edge_we    = (r_state == S_EDGE) && fits;
        edge_waddr = ADDR_W'(r_fill + FILL_W'(r_k));
        edge_raddr = (r_state == S_SJ) ? ADDR_W'(r_j) : ADDR_W'(r_i);
        n_cnt      = (r_edge_q == r_key && r_cnt != 2'd2) ? r_cnt + 2'd1 : r_cnt;
        n_j        = r_j + FILL_W'(1);

        used_we    = 1'b0;
        used_addr  = mv_u[IDX_W-1:BIT_W];
        used_wdata = r_used_q | (WORD_W'(1) << mv_u[BIT_W-1:0]);
        bnd_we     = 1'b0;
        bnd_addr   = mv_b[IDX_W-1:BIT_W];
        bnd_wdata  = r_bnd_q | (WORD_W'(1) << mv_b[BIT_W-1:0]);
        case (r_state)
            S_CLR: begin
                used_we    = 1'b1;
                bnd_we     = 1'b1;
                used_addr  = r_row;
                bnd_addr   = r_row;
                used_wdata = '0;
                bnd_wdata  = '0;
            end
            S_UMWR: used_we = (32'(mv_u) < MAX_VERTS);
            S_BMWR: bnd_we  = (32'(mv_b) < MAX_VERTS);
            S_ORD: begin
                used_addr = r_row;
                bnd_addr  = r_row;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        r_edge_q <= edge_mem[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (used_we) begin
            used_mem[used_addr] <= used_wdata;
        end
        r_used_q <= used_mem[used_addr];
    end

    always_ff @(posedge i_clk) begin
        if (bnd_we) begin
            bnd_mem[bnd_addr] <= bnd_wdata;
        end
        r_bnd_q <= bnd_mem[bnd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCNT_W'(1024);
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_row       <= '0;
            r_fill      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_row <= r_row + ROW_W'(1);
                    if (r_row == ROW_W'(ROW_CNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_a    <= i_corner_a;
                        r_b    <= i_corner_b;
                        r_c    <= i_corner_c;
                        r_last <= i_last_face;
                        r_k    <= '0;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (!fits) begin
                        r_dropped <= 1'b1;
                        r_state   <= S_CHK;
                    end else if (r_k == 2'd2) begin
                        r_fill  <= r_fill + FILL_W'(3);
                        r_k     <= '0;
                        r_state <= S_UMRD;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_UMRD: r_state <= S_UMWR;
                S_UMWR: begin
                    r_k <= r_k + 2'd1;
                    r_state <= (r_k == 2'd2) ? S_CHK : S_UMRD;
                end
                S_CHK: begin
                    r_i   <= '0;
                    r_row <= '0;
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_fill == '0) begin
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_SI;
                    end
                end
                S_SI: r_state <= S_SK;
                S_SK: begin
                    r_key   <= r_edge_q;
                    r_j     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SJ;
                end
                S_SJ: r_state <= S_SC;
                S_SC: begin
                    r_cnt <= n_cnt;
                    r_j   <= n_j;
                    r_state <= (n_cnt == 2'd2 || n_j == r_fill) ? S_SD : S_SJ;
                end
                S_SD: begin
                    r_k <= '0;
                    if (r_cnt == 2'd1) begin
                        r_state <= S_BMRD;
                    end else if (r_i + FILL_W'(1) == r_fill) begin
                        r_state <= S_ORD;
                    end else begin
                        r_i     <= r_i + FILL_W'(1);
                        r_state <= S_SI;
                    end
                end
                S_BMRD: r_state <= S_BMWR;
                S_BMWR: begin
                    if (r_k == 2'd0) begin
                        r_k     <= 2'd1;
                        r_state <= S_BMRD;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_SD;
                    end
                end
                S_ORD: r_state <= S_OLD;
                S_OLD: begin
                    r_out_valid     <= 1'b1;
                    r_word_index    <= r_row;
                    r_used_bits     <= r_used_q & mask;
                    r_boundary_bits <= r_bnd_q & mask;
                    r_overflow      <= r_dropped;
                    r_last_word     <= ((ROW_W + 1)'(r_row) + (ROW_W + 1)'(1)) == words;
                    r_state         <= S_OVL;
                end
                S_OVL: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_last_word) begin
                            r_row     <= '0;
                            r_fill    <= '0;
                            r_dropped <= 1'b0;
                            r_state   <= S_CLR;
                        end else begin
                            r_row   <= r_row + ROW_W'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_word_index    = r_word_index;
    assign o_used_bits     = r_used_bits;
    assign o_boundary_bits = r_boundary_bits;
    assign o_overflow      = r_overflow;
    assign o_last_word     = r_last_word;
endmodule

/* tb/mesh_boundary_vertex_marker_tb.sv */
// Testbench for mesh_boundary_vertex_marker: sends triangle meshes, predicts
// the used and boundary bitmap words and checks every word. Uses mbvm_pkg.
`timescale 1ns / 1ps

module mesh_boundary_vertex_marker_tb;
    import mbvm_pkg::*;

    localparam int KEY_CAP = DEF_MAX_FACES * 3;

    typedef struct packed {
        logic [ROW_W-1:0]  word_index;
        logic [WORD_W-1:0] used_bits;
        logic [WORD_W-1:0] boundary_bits;
        logic              overflow;
        logic              last_word;
    } t_bitmap_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [VCNT_W-1:0]  i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [IDX_W-1:0]   i_corner_a;
    logic [IDX_W-1:0]   i_corner_b;
    logic [IDX_W-1:0]   i_corner_c;
    logic               i_last_face;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [ROW_W-1:0]   o_word_index;
    logic [WORD_W-1:0]  o_used_bits;
    logic [WORD_W-1:0]  o_boundary_bits;
    logic               o_overflow;
    logic               o_last_word;

    t_bitmap_word       bitmap_q[$];
    logic [KEY_W-1:0]   mesh_keys[$];
    bit                 mesh_used[IDX_LIMIT];
    bit                 mesh_dropped;
    logic [VCNT_W-1:0]  vertex_count;
    int                 fail_count;
    int                 snd_idle_pct;
    int                 rcv_idle_pct;

    mesh_boundary_vertex_marker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_corner_a      (i_corner_a),
        .i_corner_b      (i_corner_b),
        .i_corner_c      (i_corner_c),
        .i_last_face     (i_last_face),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_word_index    (o_word_index),
        .o_used_bits     (o_used_bits),
        .o_boundary_bits (o_boundary_bits),
        .o_overflow      (o_overflow),
        .o_last_word     (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [KEY_W-1:0] edge_key(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        return (a < b) ? {a, b} : {b, a};
    endfunction

    function automatic void clear_mesh();
        mesh_keys.delete();
        foreach (mesh_used[v]) mesh_used[v] = 1'b0;
        mesh_dropped = 1'b0;
    endfunction

    function automatic void predict_bitmaps();
        int           key_uses[int];
        bit           bnd[IDX_LIMIT];
        int           count;
        int           words;
        int           v;
        t_bitmap_word w;
        foreach (mesh_keys[k]) begin
            if (key_uses.exists(mesh_keys[k])) key_uses[mesh_keys[k]]++;
            else key_uses[mesh_keys[k]] = 1;
        end
        foreach (key_uses[k]) begin
            if (key_uses[k] == 1) begin
                bnd[k >> IDX_W] = 1'b1;
                bnd[k % IDX_LIMIT] = 1'b1;
            end
        end
        count = vertex_count;
        if (count < 1) count = 1;
        if (count > DEF_MAX_VERTS) count = DEF_MAX_VERTS;
        words = (count + WORD_W - 1) / WORD_W;
        for (int r = 0; r < words; r++) begin
            w = '0;
            w.word_index = r[ROW_W-1:0];
            for (int b = 0; b < WORD_W; b++) begin
                v = r * WORD_W + b;
                if (v < count) begin
                    w.used_bits[b] = mesh_used[v];
                    w.boundary_bits[b] = bnd[v];
                end
            end
            w.overflow = mesh_dropped;
            w.last_word = (r + 1 == words);
            bitmap_q.push_back(w);
        end
        clear_mesh();
    endfunction

    function automatic void accept_face(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                        logic [IDX_W-1:0] c, logic last);
        if (mesh_keys.size() + 3 <= KEY_CAP) begin
            mesh_used[a] = 1'b1;
            mesh_used[b] = 1'b1;
            mesh_used[c] = 1'b1;
            mesh_keys.push_back(edge_key(a, b));
            mesh_keys.push_back(edge_key(b, c));
            mesh_keys.push_back(edge_key(c, a));
        end else begin
            mesh_dropped = 1'b1;
        end
        if (last) predict_bitmaps();
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_bitmap_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bitmap_q.size() == 0) begin
                report_mismatch("unexpected word", o_word_index, '0);
            end else begin
                want = bitmap_q.pop_front();
                if (o_word_index !== want.word_index)
                    report_mismatch("word_index", o_word_index, want.word_index);
                if (o_used_bits !== want.used_bits)
                    report_mismatch("used_bits", o_used_bits, want.used_bits);
                if (o_boundary_bits !== want.boundary_bits)
                    report_mismatch("boundary_bits", o_boundary_bits, want.boundary_bits);
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", o_overflow, want.overflow);
                if (o_last_word !== want.last_word)
                    report_mismatch("last_word", o_last_word, want.last_word);
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (rcv_idle_pct > 0) && ($urandom_range(99) < rcv_idle_pct);
    end

    task automatic send_face(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                             logic [IDX_W-1:0] c, logic last);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_corner_a  = a;
        i_corner_b  = b;
        i_corner_c  = c;
        i_last_face = last;
        do @(posedge i_clk); while (o_in_stall);
        accept_face(a, b, c, last);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (bitmap_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_vertex_count(logic [VCNT_W-1:0] value);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        vertex_count = value;
    endtask

    function automatic logic [IDX_W-1:0] pick_corner(int base);
        if ($urandom_range(3) == 0) return IDX_W'($urandom_range(IDX_LIMIT - 1));
        return IDX_W'((base + $urandom_range(7)) % IDX_LIMIT);
    endfunction

    task automatic send_random_mesh();
        int faces;
        int base;
        int v;
        faces = $urandom_range(1, 12);
        base  = $urandom_range(IDX_LIMIT - 1);
        v     = base;
        for (int f = 0; f < faces; f++) begin
            if ($urandom_range(1)) begin
                // strip: neighbors share an edge
                send_face(IDX_W'(v % IDX_LIMIT), IDX_W'((v + 1) % IDX_LIMIT),
                          IDX_W'((v + 2) % IDX_LIMIT), f == faces - 1);
                v++;
            end else begin
                send_face(pick_corner(base), pick_corner(base), pick_corner(base),
                          f == faces - 1);
            end
        end
    endtask

    task automatic test_directed();
        send_face(0, 1023, 512, 1'b1);
        send_face(1023, 1023, 1023, 1'b1);
        send_face(0, 0, 0, 1'b1);
        send_face(0, 1, 2, 1'b0);
        send_face(2, 1, 3, 1'b1);
        send_face(5, 6, 7, 1'b0);
        send_face(6, 5, 8, 1'b0);
        send_face(5, 6, 9, 1'b1);
        send_face(10, 10, 11, 1'b1);
        send_face(1000, 1001, 1002, 1'b0);
        send_face(1002, 1001, 1000, 1'b1);
        send_face(341, 682, 1023, 1'b1);
    endtask

    task automatic test_vertex_count();
        logic [VCNT_W-1:0] settings[7] = '{0, 1, 64, 65, 1024, 2047, 3};
        foreach (settings[s]) begin
            write_vertex_count(settings[s]);
            send_face(0, 63, 64, 1'b0);
            send_face(1, 2, 1023, 1'b1);
            send_random_mesh();
        end
        write_vertex_count(VCNT_W'($urandom_range(1, 1024)));
    endtask

    task automatic test_random(int items, int snd_pct, int rcv_pct);
        int start;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        start = 0;
        while (start < items) begin
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1)) write_vertex_count(VCNT_W'($urandom_range(2047)));
                else write_vertex_count(1024);
            end
            send_random_mesh();
            start += 6;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_corner_a   = '0;
        i_corner_b   = '0;
        i_corner_c   = '0;
        i_last_face  = 1'b0;
        fail_count   = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        vertex_count = 1024;
        clear_mesh();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_vertex_count();
        test_random(150, 14, 55);
        test_random(150, 55, 14);
        test_random(150, 0, 0);
        drain();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* sim.f */
design/mbvm_pkg.sv
design/mesh_boundary_vertex_marker.sv
tb/mesh_boundary_vertex_marker_tb.sv
